>>> rtl/ctwa_pkg.sv
// ----------------------------------------------------------------------------
// ctwa_pkg: shared definitions for the aging cell table
// Table size, field widths, expiry reset value, input kind codes and result event codes.
// ----------------------------------------------------------------------------
package ctwa_pkg;

    localparam int MAX_CELLS = 16;
    localparam int IDX_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    localparam int STATION_W = 64;
    localparam int CELL_W    = 32;
    localparam int TIME_W    = 48;
    localparam int LEVEL_W   = 16;
    localparam int TAG_W     = 16;
    localparam int EXPIRY_W  = 16;

    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd2000;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ACK  = 2'd0;
    localparam t_kind KIND_MSG  = 2'd1;
    localparam t_kind KIND_TICK = 2'd2;

    typedef logic [1:0] t_event;
    localparam t_event EV_SIGNAL = 2'd0;
    localparam t_event EV_LOST   = 2'd1;
    localparam t_event EV_MSG    = 2'd2;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [STATION_W-1:0] t_station;
    typedef logic [CELL_W-1:0]    t_cell;
    typedef logic [TIME_W-1:0]    t_time;
    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic [TAG_W-1:0]     t_tag;

endpackage

>>> rtl/cell_table_with_aging.sv
// ----------------------------------------------------------------------------
// cell_table_with_aging: station-keyed cell table with expiry
// Ack and message items walk the table once in S_SCAN and then update it in
// S_ACT, which registers the result; busy is high while an item is in work.
// A tick walks the table once to age entries, then one full walk per lost
// result to pick the lowest station id.
// All walks share one entry read port and one compare unit indexed by r_idx.
// Reset clears valid bits and the cell id counter, sets expiry to EXPIRY_RESET.
// Results are single-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
module cell_table_with_aging (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [15:0]              i_cfg_wdata,
    input  logic                     start,
    output logic                     busy,
    input  ctwa_pkg::t_kind          i_kind,
    input  ctwa_pkg::t_station       i_station_id,
    input  ctwa_pkg::t_level         i_signal_dbm,
    input  ctwa_pkg::t_tag           i_message_tag,
    input  ctwa_pkg::t_time          i_now_ms,
    output logic                     o_strobe,
    output ctwa_pkg::t_event         o_event_res,
    output ctwa_pkg::t_cell          o_cell_id,
    output ctwa_pkg::t_level         o_level_dbm,
    output ctwa_pkg::t_tag           o_tag_out,
    output logic                     o_last
);
    import ctwa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_ACT  = 5'b00100,
        S_AGE  = 5'b01000,
        S_SORT = 5'b10000
    } t_state;

    // table storage
    logic [MAX_CELLS-1:0] r_valid;
    t_station             r_station [MAX_CELLS];
    t_cell                r_cell    [MAX_CELLS];
    t_time                r_seen    [MAX_CELLS];
    t_level               r_level   [MAX_CELLS];

    logic [EXPIRY_W-1:0]  r_expiry;
    t_cell                r_id_ctr, n_id_ctr;
    t_state               r_state, n_state;
    t_idx                 r_idx, n_idx;

    // latched item
    t_kind    r_kind;
    t_station r_sid;
    t_level   r_sig;
    t_tag     r_tag;
    t_time    r_now;

    // lookup results
    logic   r_hit_found, n_hit_found;
    t_idx   r_hit_idx, n_hit_idx;
    t_cell  r_hit_cell, n_hit_cell;
    t_level r_hit_level, n_hit_level;
    logic   r_free_found, n_free_found;
    t_idx   r_free_idx, n_free_idx;

    // expiry and ordering
    logic [MAX_CELLS-1:0] r_gone, n_gone;
    logic     r_best_found, n_best_found;
    t_station r_best_station, n_best_station;
    t_cell    r_best_cell, n_best_cell;
    t_idx     r_best_idx, n_best_idx;

    // result register
    logic   r_strobe, n_strobe;
    t_event r_ev, n_ev;
    t_cell  r_out_cell, n_out_cell;
    t_level r_out_level, n_out_level;
    t_tag   r_out_tag, n_out_tag;
    logic   r_out_last, n_out_last;

    // table write controls
    logic   wr_en, wr_new, valid_set, valid_clr;
    t_idx   wr_idx;
    t_cell  new_cell;

    // shared compare unit on the entry at r_idx
    logic     last_idx, cur_hit, cur_free, expired, take;
    t_time    age;
    logic [MAX_CELLS-1:0] clr_mask;

    logic accept;
    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        last_idx = (r_idx == IDX_W'(MAX_CELLS - 1));
        cur_hit  = r_valid[r_idx] && (r_station[r_idx] == r_sid);
        cur_free = !r_valid[r_idx];
        age      = r_now - r_seen[r_idx];
        expired  = r_valid[r_idx] && (age > {{(TIME_W-EXPIRY_W){1'b0}}, r_expiry});
        take     = r_gone[r_idx] && (!r_best_found || (r_station[r_idx] < r_best_station));
        new_cell = r_id_ctr + CELL_W'(1);
    end

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_id_ctr       = r_id_ctr;
        n_hit_found    = r_hit_found;
        n_hit_idx      = r_hit_idx;
        n_hit_cell     = r_hit_cell;
        n_hit_level    = r_hit_level;
        n_free_found   = r_free_found;
        n_free_idx     = r_free_idx;
        n_gone         = r_gone;
        n_best_found   = r_best_found;
        n_best_station = r_best_station;
        n_best_cell    = r_best_cell;
        n_best_idx     = r_best_idx;
        n_strobe       = 1'b0;
        n_ev           = r_ev;
        n_out_cell     = r_out_cell;
        n_out_level    = r_out_level;
        n_out_tag      = r_out_tag;
        n_out_last     = r_out_last;
        wr_en          = 1'b0;
        wr_new         = 1'b0;
        wr_idx         = r_hit_idx;
        valid_set      = 1'b0;
        valid_clr      = 1'b0;
        clr_mask       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx        = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_gone       = '0;
                    n_best_found = 1'b0;
                    if (i_kind == KIND_ACK || i_kind == KIND_MSG) begin
                        n_state = S_SCAN;
                    end else if (i_kind == KIND_TICK) begin
                        n_state = S_AGE;
                    end
                end
            end
            S_SCAN: begin
                if (cur_hit && !r_hit_found) begin
                    n_hit_found = 1'b1;
                    n_hit_idx   = r_idx;
                    n_hit_cell  = r_cell[r_idx];
                    n_hit_level = r_level[r_idx];
                end
                if (cur_free && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
                n_idx = r_idx + IDX_W'(1);
                if (last_idx) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state     = S_IDLE;
                n_out_last  = 1'b1;
                n_out_level = '0;
                n_out_tag   = '0;
                if (r_kind == KIND_ACK) begin
                    n_ev        = EV_SIGNAL;
                    n_out_level = r_sig;
                    if (r_hit_found) begin
                        wr_en      = 1'b1;
                        wr_idx     = r_hit_idx;
                        n_strobe   = (r_hit_level != r_sig);
                        n_out_cell = r_hit_cell;
                    end else if (r_free_found) begin
                        // new station: take the lowest free entry and a fresh id
                        wr_en      = 1'b1;
                        wr_new     = 1'b1;
                        valid_set  = 1'b1;
                        wr_idx     = r_free_idx;
                        n_id_ctr   = new_cell;
                        n_strobe   = (r_sig != '0);
                        n_out_cell = new_cell;
                    end
                end else begin
                    n_ev       = EV_MSG;
                    n_out_tag  = r_tag;
                    n_out_cell = r_hit_cell;
                    n_strobe   = r_hit_found;
                end
            end
            S_AGE: begin
                if (expired) begin
                    valid_clr     = 1'b1;
                    n_gone[r_idx] = 1'b1;
                end
                n_idx = r_idx + IDX_W'(1);
                if (last_idx) begin
                    n_state = (n_gone == '0) ? S_IDLE : S_SORT;
                end
            end
            S_SORT: begin
                if (take) begin
                    n_best_found   = 1'b1;
                    n_best_station = r_station[r_idx];
                    n_best_cell    = r_cell[r_idx];
                    n_best_idx     = r_idx;
                end
                n_idx = r_idx + IDX_W'(1);
                if (last_idx) begin
                    // emit the lowest remaining station, then rescan the rest
                    for (int j = 0; j < MAX_CELLS; j++) begin
                        clr_mask[j] = (n_best_idx == IDX_W'(j));
                    end
                    n_gone       = r_gone & ~clr_mask;
                    n_strobe     = 1'b1;
                    n_ev         = EV_LOST;
                    n_out_cell   = n_best_cell;
                    n_out_level  = '0;
                    n_out_tag    = '0;
                    n_out_last   = (n_gone == '0);
                    n_best_found = 1'b0;
                    n_idx        = '0;
                    n_state      = (n_gone == '0) ? S_IDLE : S_SORT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_id_ctr <= '0;
            r_expiry <= EXPIRY_RESET;
            r_strobe <= 1'b0;
            r_gone   <= '0;
        end else begin
            r_state  <= n_state;
            r_id_ctr <= n_id_ctr;
            r_strobe <= n_strobe;
            r_gone   <= n_gone;
            if (i_cfg_we) begin
                r_expiry <= i_cfg_wdata;
            end
            if (valid_set) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (valid_clr) begin
                r_valid[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_sid  <= i_station_id;
            r_sig  <= i_signal_dbm;
            r_tag  <= i_message_tag;
            r_now  <= i_now_ms;
        end
        if (wr_en) begin
            r_seen[wr_idx]  <= r_now;
            r_level[wr_idx] <= r_sig;
        end
        if (wr_new) begin
            r_station[wr_idx] <= r_sid;
            r_cell[wr_idx]    <= new_cell;
        end
        r_idx          <= n_idx;
        r_hit_found    <= n_hit_found;
        r_hit_idx      <= n_hit_idx;
        r_hit_cell     <= n_hit_cell;
        r_hit_level    <= n_hit_level;
        r_free_found   <= n_free_found;
        r_free_idx     <= n_free_idx;
        r_best_found   <= n_best_found;
        r_best_station <= n_best_station;
        r_best_cell    <= n_best_cell;
        r_best_idx     <= n_best_idx;
        r_ev           <= n_ev;
        r_out_cell     <= n_out_cell;
        r_out_level    <= n_out_level;
        r_out_tag      <= n_out_tag;
        r_out_last     <= n_out_last;
    end

    assign o_strobe    = r_strobe;
    assign o_event_res = r_ev;
    assign o_cell_id   = r_out_cell;
    assign o_level_dbm = r_out_level;
    assign o_tag_out   = r_out_tag;
    assign o_last      = r_out_last;

    // results come only out of the update cycle or the end of an ordering walk
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_ACT || $past(r_state) == S_SORT))
        else $error("result strobe outside update or ordering walk");

    // the final result of an item frees the block
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> (r_state == S_IDLE))
        else $error("busy after final result");

    // only a tick gives more than one result
    a_more_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> (r_state == S_SORT && r_gone != '0))
        else $error("non-final result without pending lost entries");

    // an ordering walk always has entries left to report
    a_sort_gone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |-> (r_gone != '0))
        else $error("ordering walk with no expired entries");

    // expired entries are no longer valid
    a_gone_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |-> ((r_gone & r_valid) == '0))
        else $error("expired entry still marked valid");

endmodule
